[rtl/psam_pkg.sv]
// Shared types and constants for the parity stripe address mapper.
// Used by every module in the rtl folder; depends on nothing.
package psam_pkg;

  localparam int CNT_W    = 9;
  localparam int REM_W    = CNT_W + 1;
  localparam int STEPS    = 4;
  localparam int NCELL    = 11;
  localparam int DVD_W    = NCELL * STEPS;
  localparam int SUM_W    = 48;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_PARITY_START = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PARITY_STEP  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MEMBER_TOTAL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MEMBER_BYTES = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BYTES  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STRIPE_LIMIT = 3'd5;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_RANGE = 2'd1;
  localparam logic [1:0] STAT_END   = 2'd2;

  typedef struct packed {
    logic        valid;
    logic        op;
    logic [31:0] stripe;
    logic [15:0] idx;
  } item_t;

endpackage

[rtl/psam_cell.sv]
// One cell of the modulo chain: a few restoring remainder steps, then a register.
// Depends on psam_pkg.
module psam_cell (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [8:0]            count,
  input  psam_pkg::item_t       item_i,
  input  logic [8:0]            rem_i,
  input  logic [psam_pkg::DVD_W-1:0] dvd_i,
  output psam_pkg::item_t       item_o,
  output logic [8:0]            rem_o,
  output logic [psam_pkg::DVD_W-1:0] dvd_o
);
  import psam_pkg::*;

  item_t              item_r;
  logic [CNT_W-1:0]   rem_r, rem_nxt;
  logic [DVD_W-1:0]   dvd_r, dvd_nxt;

  always_comb begin
    logic [REM_W-1:0] r;
    r       = '0;
    rem_nxt = rem_i;
    dvd_nxt = dvd_i;
    for (int s = 0; s < STEPS; s++) begin
      r = {rem_nxt, dvd_nxt[DVD_W-1]};
      if (r >= {1'b0, count}) begin
        r = r - {1'b0, count};
      end
      rem_nxt = r[CNT_W-1:0];
      dvd_nxt = {dvd_nxt[DVD_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_r.valid <= 1'b0;
    end else begin
      item_r.valid <= item_i.valid;
    end
    item_r.op     <= item_i.op;
    item_r.stripe <= item_i.stripe;
    item_r.idx    <= item_i.idx;
    rem_r         <= rem_nxt;
    dvd_r         <= dvd_nxt;
  end

  assign item_o = item_r;
  assign rem_o  = rem_r;
  assign dvd_o  = dvd_r;
endmodule

[rtl/psam_offset.sv]
// Target selection, slot offset products, end checks and output registers.
// Depends on psam_pkg.
module psam_offset #(
  parameter int OFFSET_BITS = 40
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [8:0]             count,
  input  logic [31:0]            member_bytes,
  input  logic [24:0]            block_bytes,
  input  logic [20:0]            stripe_limit,
  input  psam_pkg::item_t        item_i,
  input  logic [8:0]             rem_i,
  output logic                   out_valid,
  output logic [7:0]             out_parity_member,
  output logic [16:0]            out_target_member,
  output logic [OFFSET_BITS-1:0] out_target_offset,
  output logic [OFFSET_BITS-1:0] out_parity_offset,
  output logic [1:0]             out_status
);
  import psam_pkg::*;

  localparam logic [SUM_W:0] END_LIM =
    (OFFSET_BITS < SUM_W) ? ((SUM_W+1)'(1) << OFFSET_BITS) : {(SUM_W+1){1'b1}};

  logic [CNT_W-1:0] parity;
  logic [16:0]      target;
  logic             s_ok, t_ok, p_ok;

  always_comb begin
    parity = (count == '0) ? '0 : rem_i;
    target = {1'b0, item_i.idx};
    if (!item_i.op && (item_i.idx >= {7'd0, parity})) begin
      target = {1'b0, item_i.idx} + 17'd1;
    end
    s_ok = (item_i.stripe < {11'd0, stripe_limit});
    t_ok = s_ok && (target < {8'd0, count});
    p_ok = s_ok && (parity < count);
  end

  logic             a_vld_r, a_tok_r, a_pok_r;
  logic [CNT_W-1:0] a_par_r;
  logic [16:0]      a_tgt_r;
  logic [40:0]      a_tm_r, a_pm_r, a_tot_r;
  logic [45:0]      a_sb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= item_i.valid;
    end
    a_tok_r <= t_ok;
    a_pok_r <= p_ok;
    a_par_r <= parity;
    a_tgt_r <= target;
    a_tm_r  <= target[CNT_W-1:0] * member_bytes;
    a_pm_r  <= parity * member_bytes;
    a_tot_r <= count * member_bytes;
    a_sb_r  <= item_i.stripe[20:0] * block_bytes;
  end

  logic             b_vld_r, b_tok_r, b_pok_r;
  logic [CNT_W-1:0] b_par_r;
  logic [16:0]      b_tgt_r;
  logic [SUM_W-1:0] b_tb_r, b_te_r, b_pb_r, b_pe_r, b_tot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else begin
      b_vld_r <= a_vld_r;
    end
    b_tok_r <= a_tok_r;
    b_pok_r <= a_pok_r;
    b_par_r <= a_par_r;
    b_tgt_r <= a_tgt_r;
    b_tb_r  <= SUM_W'(a_tm_r) + SUM_W'(a_sb_r);
    b_te_r  <= SUM_W'(a_tm_r) + SUM_W'(a_sb_r) + SUM_W'(block_bytes);
    b_pb_r  <= SUM_W'(a_pm_r) + SUM_W'(a_sb_r);
    b_pe_r  <= SUM_W'(a_pm_r) + SUM_W'(a_sb_r) + SUM_W'(block_bytes);
    b_tot_r <= SUM_W'(a_tot_r);
  end

  logic t_over, p_over;
  logic [OFFSET_BITS+SUM_W-1:0] t_ext, p_ext;
  logic [1:0] status;

  always_comb begin
    t_over = (b_te_r > b_tot_r) || ({1'b0, b_te_r} > END_LIM);
    p_over = (b_pe_r > b_tot_r) || ({1'b0, b_pe_r} > END_LIM);
    t_ext  = {{OFFSET_BITS{1'b0}}, b_tb_r};
    p_ext  = {{OFFSET_BITS{1'b0}}, b_pb_r};
    if (!b_tok_r) begin
      status = STAT_RANGE;
    end else if (t_over) begin
      status = STAT_END;
    end else begin
      status = STAT_OK;
    end
  end

  logic                   o_vld_r;
  logic [7:0]             o_par_r;
  logic [16:0]            o_tgt_r;
  logic [OFFSET_BITS-1:0] o_toff_r, o_poff_r;
  logic [1:0]             o_st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
    end else begin
      o_vld_r <= b_vld_r;
    end
    o_par_r  <= b_par_r[7:0];
    o_tgt_r  <= b_tgt_r;
    o_toff_r <= (status == STAT_OK) ? t_ext[OFFSET_BITS-1:0] : '0;
    o_poff_r <= (b_pok_r && !p_over) ? p_ext[OFFSET_BITS-1:0] : '0;
    o_st_r   <= status;
  end

  assign out_valid         = o_vld_r;
  assign out_parity_member = o_par_r;
  assign out_target_member = o_tgt_r;
  assign out_target_offset = o_toff_r;
  assign out_parity_offset = o_poff_r;
  assign out_status        = o_st_r;
endmodule

[rtl/parity_stripe_address_mapper_core.sv]
// Top level of the parity stripe address mapper: configuration registers,
// the modulo cell chain and the offset back end. Depends on psam_pkg,
// psam_cell and psam_offset.
//
//  channel   ports                                  handshake
//  input     in_operation, in_stripe, in_index      start high, busy low
//  result    out_parity_member .. out_status        out_valid, one cycle
//  config    cfg_index, cfg_data                    cfg_we
//
// An item is accepted in every cycle; busy is always low.
// Its result passes through 11 cells of the parity modulo chain, one product
// stage, one sum stage and the output register.
// Reset clears the pipeline valid bits and loads the register defaults.
// The receiver cannot stall, so nothing in the pipeline ever holds.
module parity_stripe_address_mapper_core #(
  parameter int MAX_MEMBERS = 256,
  parameter int OFFSET_BITS = 40
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_operation,
  input  logic [31:0]                       in_stripe,
  input  logic [15:0]                       in_index,
  output logic                              out_valid,
  output logic [7:0]                        out_parity_member,
  output logic [16:0]                       out_target_member,
  output logic [OFFSET_BITS-1:0]            out_target_offset,
  output logic [OFFSET_BITS-1:0]            out_parity_offset,
  output logic [1:0]                        out_status,
  input  logic                              cfg_we,
  input  logic [psam_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [psam_pkg::CFG_DAT_W-1:0]    cfg_data
);
  import psam_pkg::*;

  localparam int LAT = NCELL + 3;

  logic [7:0]  pstart_r;
  logic [7:0]  pstep_r;
  logic [8:0]  mtotal_r;
  logic [31:0] mbytes_r;
  logic [24:0] bbytes_r;
  logic [20:0] slimit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pstart_r <= 8'd0;
      pstep_r  <= 8'd1;
      mtotal_r <= 9'd4;
      mbytes_r <= 32'd16777216;
      bbytes_r <= 25'd65536;
      slimit_r <= 21'd256;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PARITY_START: pstart_r <= cfg_data[7:0];
        REG_PARITY_STEP:  pstep_r  <= cfg_data[7:0];
        REG_MEMBER_TOTAL: mtotal_r <= cfg_data[8:0];
        REG_MEMBER_BYTES: mbytes_r <= cfg_data;
        REG_BLOCK_BYTES:  bbytes_r <= cfg_data[24:0];
        REG_STRIPE_LIMIT: slimit_r <= cfg_data[20:0];
        default: ;
      endcase
    end
  end

  logic [CNT_W-1:0] count;
  assign count = ({8'd0, mtotal_r} > 17'(MAX_MEMBERS)) ? CNT_W'(MAX_MEMBERS) : mtotal_r;

  assign busy = 1'b0;

  item_t            items [NCELL+1];
  logic [CNT_W-1:0] rems  [NCELL+1];
  logic [DVD_W-1:0] dvds  [NCELL+1];

  assign items[0].valid  = start && !busy;
  assign items[0].op     = in_operation;
  assign items[0].stripe = in_stripe;
  assign items[0].idx    = in_index;
  assign rems[0]         = '0;
  assign dvds[0]         = DVD_W'(in_stripe) * DVD_W'(pstep_r) + DVD_W'(pstart_r);

  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    psam_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .count  (count),
      .item_i (items[g]),
      .rem_i  (rems[g]),
      .dvd_i  (dvds[g]),
      .item_o (items[g+1]),
      .rem_o  (rems[g+1]),
      .dvd_o  (dvds[g+1])
    );
  end

  psam_offset #(.OFFSET_BITS(OFFSET_BITS)) u_offset (
    .clk               (clk),
    .rst_n             (rst_n),
    .count             (count),
    .member_bytes      (mbytes_r),
    .block_bytes       (bbytes_r),
    .stripe_limit      (slimit_r),
    .item_i            (items[NCELL]),
    .rem_i             (rems[NCELL]),
    .out_valid         (out_valid),
    .out_parity_member (out_parity_member),
    .out_target_member (out_target_member),
    .out_target_offset (out_target_offset),
    .out_parity_offset (out_parity_offset),
    .out_status        (out_status)
  );

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##LAT out_valid) else $error("item lost in pipeline");
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == STAT_OK || out_status == STAT_RANGE ||
                   out_status == STAT_END)) else $error("bad status code");
  a_toff: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != STAT_OK) |-> out_target_offset == '0)
    else $error("offset set on failed item");
`endif
endmodule
